// File: rtl/i2c_master_status_sequencer_unit_macros.svh
// Assertion macros for the RTL that checks itself.
// Each one samples on the rising clock edge and is quiet while reset is high.
`ifndef I2C_MASTER_STATUS_SEQUENCER_UNIT_MACROS_SVH
`define I2C_MASTER_STATUS_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication.
`define I2CMS_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication.
`define I2CMS_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// File: rtl/i2cms_pkg.sv
`default_nettype none

package i2cms_pkg;

   // Field widths
   localparam int ADDR_W = 7;
   localparam int LEN_W  = 16;
   localparam int BYTE_W = 8;
   localparam int ACK_W  = 2;
   localparam int OC_W   = 3;

   // Engine status codes
   localparam logic [BYTE_W-1:0] ST_BUS_ERROR = 8'h00;
   localparam logic [BYTE_W-1:0] ST_START     = 8'h08;
   localparam logic [BYTE_W-1:0] ST_RESTART   = 8'h10;
   localparam logic [BYTE_W-1:0] ST_WADDR_ACK = 8'h18;
   localparam logic [BYTE_W-1:0] ST_WADDR_NAK = 8'h20;
   localparam logic [BYTE_W-1:0] ST_TX_ACK    = 8'h28;
   localparam logic [BYTE_W-1:0] ST_TX_NAK    = 8'h30;
   localparam logic [BYTE_W-1:0] ST_RADDR_ACK = 8'h40;
   localparam logic [BYTE_W-1:0] ST_RADDR_NAK = 8'h48;
   localparam logic [BYTE_W-1:0] ST_RX_ACK    = 8'h50;
   localparam logic [BYTE_W-1:0] ST_RX_NAK    = 8'h58;

   // Item modes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_EVENT = 1'b1;

   // Outcome codes
   localparam logic [OC_W-1:0] OC_BUSY = 3'd0;
   localparam logic [OC_W-1:0] OC_DONE = 3'd1;
   localparam logic [OC_W-1:0] OC_NAK  = 3'd2;
   localparam logic [OC_W-1:0] OC_BERR = 3'd3;
   localparam logic [OC_W-1:0] OC_UNEX = 3'd4;

   // ACK control codes
   localparam logic [ACK_W-1:0] ACK_KEEP   = 2'd0;
   localparam logic [ACK_W-1:0] ACK_ASSERT = 2'd1;
   localparam logic [ACK_W-1:0] ACK_DROP   = 2'd2;

   typedef struct packed {
      logic              mode;
      logic [ADDR_W-1:0] slave_addr;
      logic              read_not_write;
      logic              ignore_nak;
      logic [LEN_W-1:0]  msg_length;
      logic              int_pending;
      logic [BYTE_W-1:0] status_code;
      logic [BYTE_W-1:0] rx_byte;
      logic [BYTE_W-1:0] tx_byte;
   } req_type;

   typedef struct packed {
      logic              issue_start;
      logic              handled;
      logic              write_valid;
      logic [BYTE_W-1:0] out_byte;
      logic              rx_valid;
      logic [BYTE_W-1:0] rx_data;
      logic [LEN_W-1:0]  buf_position;
      logic [ACK_W-1:0]  ack_control;
      logic              send_stop;
      logic              clear_int;
      logic              finished;
      logic [OC_W-1:0]   outcome;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] target_addr;
      logic              is_read;
      logic              nak_ignored;
      logic [LEN_W-1:0]  bytes_left;
      logic [LEN_W-1:0]  position;
      logic [OC_W-1:0]   last_outcome;
   } state_type;

endpackage

`default_nettype wire

// File: rtl/i2cms_if.sv
`default_nettype none

// Request channel: start items and engine status events
interface i2cms_req_if
   import i2cms_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [ADDR_W-1:0] slave_addr;
   logic              read_not_write;
   logic              ignore_nak;
   logic [LEN_W-1:0]  msg_length;
   logic              int_pending;
   logic [BYTE_W-1:0] status_code;
   logic [BYTE_W-1:0] rx_byte;
   logic [BYTE_W-1:0] tx_byte;

   modport source (
      output valid, mode, slave_addr, read_not_write, ignore_nak, msg_length,
             int_pending, status_code, rx_byte, tx_byte,
      input  ready
   );
   modport sink (
      input  valid, mode, slave_addr, read_not_write, ignore_nak, msg_length,
             int_pending, status_code, rx_byte, tx_byte,
      output ready
   );
endinterface

// Response channel: one action item per request item
interface i2cms_rsp_if
   import i2cms_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic              issue_start;
   logic              handled;
   logic              write_valid;
   logic [BYTE_W-1:0] out_byte;
   logic              rx_valid;
   logic [BYTE_W-1:0] rx_data;
   logic [LEN_W-1:0]  buf_position;
   logic [ACK_W-1:0]  ack_control;
   logic              send_stop;
   logic              clear_int;
   logic              finished;
   logic [OC_W-1:0]   outcome;

   modport source (
      output valid, issue_start, handled, write_valid, out_byte, rx_valid, rx_data,
             buf_position, ack_control, send_stop, clear_int, finished, outcome,
      input  ready
   );
   modport sink (
      input  valid, issue_start, handled, write_valid, out_byte, rx_valid, rx_data,
             buf_position, ack_control, send_stop, clear_int, finished, outcome,
      output ready
   );
endinterface

`default_nettype wire

// File: rtl/i2cms_step.sv
`default_nettype none

module i2cms_step
   import i2cms_pkg::*;
(
   input  req_type   req_cur,
   input  state_type state_cur,
   output state_type state_nxt,
   output rsp_type   rsp_nxt
);

   logic             end_msg;
   logic             do_tx;
   logic             do_rx;
   logic             do_radr;
   logic [LEN_W-1:0] left_dec;

   always_comb begin
      state_nxt = state_cur;
      rsp_nxt   = '0;
      end_msg   = 1'b0;
      do_tx     = 1'b0;
      do_rx     = 1'b0;
      do_radr   = 1'b0;
      left_dec  = state_cur.bytes_left - LEN_W'(1);

      if (req_cur.mode == MODE_START) begin
         // Load a new message and request START
         state_nxt.target_addr  = req_cur.slave_addr;
         state_nxt.is_read      = req_cur.read_not_write;
         state_nxt.nak_ignored  = req_cur.ignore_nak;
         state_nxt.bytes_left   = req_cur.msg_length;
         state_nxt.position     = '0;
         state_nxt.last_outcome = OC_BUSY;
         rsp_nxt.issue_start    = 1'b1;
      end else if (req_cur.int_pending) begin
         rsp_nxt.handled   = 1'b1;
         rsp_nxt.clear_int = 1'b1;

         // Decode the engine status
         unique case (req_cur.status_code) inside
            ST_START, ST_RESTART: begin
               rsp_nxt.write_valid = 1'b1;
               rsp_nxt.out_byte    = {state_cur.target_addr, state_cur.is_read};
            end
            ST_WADDR_NAK, ST_TX_NAK: begin
               if (!state_cur.nak_ignored) begin
                  state_nxt.last_outcome = OC_NAK;
                  end_msg                = 1'b1;
               end else begin
                  do_tx = 1'b1;
               end
            end
            ST_WADDR_ACK, ST_TX_ACK: begin
               do_tx = 1'b1;
            end
            ST_RADDR_NAK: begin
               if (!state_cur.nak_ignored) begin
                  state_nxt.last_outcome = OC_NAK;
                  end_msg                = 1'b1;
               end else begin
                  do_radr = 1'b1;
               end
            end
            ST_RADDR_ACK: begin
               do_radr = 1'b1;
            end
            ST_RX_NAK: begin
               if (state_cur.bytes_left == LEN_W'(1)) begin
                  // Last byte: store it without advancing and finish
                  rsp_nxt.rx_valid       = 1'b1;
                  rsp_nxt.rx_data        = req_cur.rx_byte;
                  rsp_nxt.buf_position   = state_cur.position;
                  state_nxt.bytes_left   = '0;
                  state_nxt.last_outcome = OC_DONE;
                  end_msg                = 1'b1;
               end else if (!state_cur.nak_ignored) begin
                  state_nxt.last_outcome = OC_NAK;
                  end_msg                = 1'b1;
               end else begin
                  do_rx = 1'b1;
               end
            end
            ST_RX_ACK: begin
               do_rx = 1'b1;
            end
            ST_BUS_ERROR: begin
               state_nxt.last_outcome = OC_BERR;
               end_msg                = 1'b1;
            end
            default: begin
               state_nxt.last_outcome = OC_UNEX;
               end_msg                = 1'b1;
            end
         endcase

         // Send the next data byte or finish the write
         if (do_tx) begin
            if (state_cur.bytes_left != '0) begin
               rsp_nxt.write_valid  = 1'b1;
               rsp_nxt.out_byte     = req_cur.tx_byte;
               rsp_nxt.buf_position = state_cur.position;
               state_nxt.position   = state_cur.position + LEN_W'(1);
               state_nxt.bytes_left = left_dec;
            end else begin
               state_nxt.last_outcome = OC_DONE;
               end_msg                = 1'b1;
            end
         end

         // Keep ACK on while more than one byte is to come
         if (do_radr && state_cur.bytes_left > LEN_W'(1)) begin
            rsp_nxt.ack_control = ACK_ASSERT;
         end

         // Store the received byte; saturate the count at zero
         if (do_rx) begin
            rsp_nxt.rx_valid     = 1'b1;
            rsp_nxt.rx_data      = req_cur.rx_byte;
            rsp_nxt.buf_position = state_cur.position;
            state_nxt.position   = state_cur.position + LEN_W'(1);
            if (state_cur.bytes_left != '0) begin
               state_nxt.bytes_left = left_dec;
            end
            if (state_nxt.bytes_left == LEN_W'(1)) begin
               rsp_nxt.ack_control = ACK_DROP;
            end
         end

         if (end_msg) begin
            rsp_nxt.send_stop = 1'b1;
            rsp_nxt.finished  = 1'b1;
         end
      end

      rsp_nxt.outcome = state_nxt.last_outcome;
   end

endmodule

`default_nettype wire

// File: rtl/i2c_master_status_sequencer_unit.sv
// An accepted item is held in the input register, then moves into the result register that drives rsp_chan.
// Throughput: one item per cycle; the input register refills as its item moves into
// the result register, so the rate is set by the result handshake alone.
// Reset (synchronous, active high): both channel registers empty, message state and
// outcome cleared to zero.
`default_nettype none

module i2c_master_status_sequencer_unit
   import i2cms_pkg::*;
(
   input  wire           clock,
   input  wire           reset,
   i2cms_req_if.sink     req_chan,
   i2cms_rsp_if.source   rsp_chan
);

   `include "i2c_master_status_sequencer_unit_macros.svh"

   logic      req_valid_ff;
   req_type   req_ff;
   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;
   rsp_type   rsp_in;
   logic      advance;
   req_type   req_item;

   // Gather the request payload
   assign req_item = '{
      mode:           req_chan.mode,
      slave_addr:     req_chan.slave_addr,
      read_not_write: req_chan.read_not_write,
      ignore_nak:     req_chan.ignore_nak,
      msg_length:     req_chan.msg_length,
      int_pending:    req_chan.int_pending,
      status_code:    req_chan.status_code,
      rx_byte:        req_chan.rx_byte,
      tx_byte:        req_chan.tx_byte
   };

   // Move the held item into the result register when that register frees up
   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;

   i2cms_step u_step (
      .req_cur   (req_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .rsp_nxt   (rsp_in)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         req_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         req_ff <= req_item;
      end
   end

   // Message state advances with each item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Drive the response channel
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.issue_start  = rsp_ff.issue_start;
   assign rsp_chan.handled      = rsp_ff.handled;
   assign rsp_chan.write_valid  = rsp_ff.write_valid;
   assign rsp_chan.out_byte     = rsp_ff.out_byte;
   assign rsp_chan.rx_valid     = rsp_ff.rx_valid;
   assign rsp_chan.rx_data      = rsp_ff.rx_data;
   assign rsp_chan.buf_position = rsp_ff.buf_position;
   assign rsp_chan.ack_control  = rsp_ff.ack_control;
   assign rsp_chan.send_stop    = rsp_ff.send_stop;
   assign rsp_chan.clear_int    = rsp_ff.clear_int;
   assign rsp_chan.finished     = rsp_ff.finished;
   assign rsp_chan.outcome      = rsp_ff.outcome;

   // Checks
   `I2CMS_ASSERT_NEXT(a_hold_input, req_valid_ff && !advance, req_valid_ff,
      "held request item was dropped")
   `I2CMS_ASSERT_NOW(a_start_busy, rsp_valid_ff && rsp_ff.issue_start,
      rsp_ff.outcome == OC_BUSY && !rsp_ff.handled && !rsp_ff.send_stop,
      "start item result carries event actions")
   `I2CMS_ASSERT_NOW(a_stop_outcome, rsp_valid_ff && rsp_ff.send_stop,
      rsp_ff.finished && rsp_ff.outcome != OC_BUSY && rsp_ff.handled,
      "STOP without a final outcome")
   `I2CMS_ASSERT_NOW(a_one_data_dir, rsp_valid_ff && rsp_ff.write_valid,
      !rsp_ff.rx_valid && rsp_ff.ack_control == ACK_KEEP,
      "byte sent and received in the same item")

endmodule

`default_nettype wire

// File: bench/i2c_master_status_sequencer_unit_test.sv
`timescale 1ns / 100ps

module i2c_master_status_sequencer_unit_test;
   import i2cms_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 450;

   logic clock = 1'b0;
   logic reset;

   i2cms_req_if req_chan ();
   i2cms_rsp_if rsp_chan ();

   i2c_master_status_sequencer_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Free-running clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   state_type msg_ctx = '0;
   rsp_type   pending_actions [$];
   logic      quiet = 1'b0;
   int        mismatches = 0;
   int        starts_sent = 0;
   int        events_sent = 0;
   int        actions_checked = 0;
   int        cycles = 0;

   // Pick an idle length: mostly none, some short, a few long
   function automatic int idle_len();
      int roll;
      roll = $urandom_range(99);
      if (quiet || roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Expected action for one accepted item; advances the message context
   function automatic rsp_type predict_action(input req_type it);
      rsp_type act;
      logic    finish_msg;
      logic    send_next;
      logic    store_rx;
      logic    addr_read;
      act        = '0;
      finish_msg = 1'b0;
      send_next  = 1'b0;
      store_rx   = 1'b0;
      addr_read  = 1'b0;
      if (it.mode == MODE_START) begin
         msg_ctx.target_addr  = it.slave_addr;
         msg_ctx.is_read      = it.read_not_write;
         msg_ctx.nak_ignored  = it.ignore_nak;
         msg_ctx.bytes_left   = it.msg_length;
         msg_ctx.position     = '0;
         msg_ctx.last_outcome = OC_BUSY;
         act.issue_start      = 1'b1;
      end else if (it.int_pending) begin
         act.handled   = 1'b1;
         act.clear_int = 1'b1;
         case (it.status_code)
            ST_START, ST_RESTART: begin
               act.write_valid = 1'b1;
               act.out_byte    = {msg_ctx.target_addr, msg_ctx.is_read};
            end
            ST_WADDR_NAK, ST_TX_NAK: begin
               if (!msg_ctx.nak_ignored) begin
                  msg_ctx.last_outcome = OC_NAK;
                  finish_msg = 1'b1;
               end else begin
                  send_next = 1'b1;
               end
            end
            ST_WADDR_ACK, ST_TX_ACK: send_next = 1'b1;
            ST_RADDR_NAK: begin
               if (!msg_ctx.nak_ignored) begin
                  msg_ctx.last_outcome = OC_NAK;
                  finish_msg = 1'b1;
               end else begin
                  addr_read = 1'b1;
               end
            end
            ST_RADDR_ACK: addr_read = 1'b1;
            ST_RX_NAK: begin
               // Last byte of a read: store it in place and finish
               if (msg_ctx.bytes_left == 1) begin
                  act.rx_valid         = 1'b1;
                  act.rx_data          = it.rx_byte;
                  act.buf_position     = msg_ctx.position;
                  msg_ctx.bytes_left   = '0;
                  msg_ctx.last_outcome = OC_DONE;
                  finish_msg = 1'b1;
               end else if (!msg_ctx.nak_ignored) begin
                  msg_ctx.last_outcome = OC_NAK;
                  finish_msg = 1'b1;
               end else begin
                  store_rx = 1'b1;
               end
            end
            ST_RX_ACK: store_rx = 1'b1;
            ST_BUS_ERROR: begin
               msg_ctx.last_outcome = OC_BERR;
               finish_msg = 1'b1;
            end
            default: begin
               msg_ctx.last_outcome = OC_UNEX;
               finish_msg = 1'b1;
            end
         endcase

         // Send the next data byte or close a finished write
         if (send_next) begin
            if (msg_ctx.bytes_left != 0) begin
               act.write_valid    = 1'b1;
               act.out_byte       = it.tx_byte;
               act.buf_position   = msg_ctx.position;
               msg_ctx.position   = msg_ctx.position + 1'b1;
               msg_ctx.bytes_left = msg_ctx.bytes_left - 1'b1;
            end else begin
               msg_ctx.last_outcome = OC_DONE;
               finish_msg = 1'b1;
            end
         end
         if (addr_read && msg_ctx.bytes_left > 1) act.ack_control = ACK_ASSERT;

         // Store a received byte; the count saturates at zero
         if (store_rx) begin
            act.rx_valid     = 1'b1;
            act.rx_data      = it.rx_byte;
            act.buf_position = msg_ctx.position;
            msg_ctx.position = msg_ctx.position + 1'b1;
            if (msg_ctx.bytes_left != 0) msg_ctx.bytes_left = msg_ctx.bytes_left - 1'b1;
            if (msg_ctx.bytes_left == 1) act.ack_control = ACK_DROP;
         end
         if (finish_msg) begin
            act.send_stop = 1'b1;
            act.finished  = 1'b1;
         end
      end
      act.outcome = msg_ctx.last_outcome;
      return act;
   endfunction

   function automatic void check_field(input string name, input logic [LEN_W-1:0] want,
                                       input logic [LEN_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Compare each action with the oldest expectation, then queue new predictions
   always @(posedge clock) begin : scoreboard
      req_type seen;
      rsp_type got;
      rsp_type want;
      if (reset) begin
         msg_ctx = '0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.issue_start  = rsp_chan.issue_start;
            got.handled      = rsp_chan.handled;
            got.write_valid  = rsp_chan.write_valid;
            got.out_byte     = rsp_chan.out_byte;
            got.rx_valid     = rsp_chan.rx_valid;
            got.rx_data      = rsp_chan.rx_data;
            got.buf_position = rsp_chan.buf_position;
            got.ack_control  = rsp_chan.ack_control;
            got.send_stop    = rsp_chan.send_stop;
            got.clear_int    = rsp_chan.clear_int;
            got.finished     = rsp_chan.finished;
            got.outcome      = rsp_chan.outcome;
            if (pending_actions.size() == 0) begin
               $error("action item arrived with none expected");
               mismatches++;
            end else begin
               want = pending_actions.pop_front();
               actions_checked++;
               check_field("issue_start", want.issue_start, got.issue_start);
               check_field("handled", want.handled, got.handled);
               check_field("write_valid", want.write_valid, got.write_valid);
               check_field("out_byte", want.out_byte, got.out_byte);
               check_field("rx_valid", want.rx_valid, got.rx_valid);
               check_field("rx_data", want.rx_data, got.rx_data);
               check_field("buf_position", want.buf_position, got.buf_position);
               check_field("ack_control", want.ack_control, got.ack_control);
               check_field("send_stop", want.send_stop, got.send_stop);
               check_field("clear_int", want.clear_int, got.clear_int);
               check_field("finished", want.finished, got.finished);
               check_field("outcome", want.outcome, got.outcome);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            seen.mode           = req_chan.mode;
            seen.slave_addr     = req_chan.slave_addr;
            seen.read_not_write = req_chan.read_not_write;
            seen.ignore_nak     = req_chan.ignore_nak;
            seen.msg_length     = req_chan.msg_length;
            seen.int_pending    = req_chan.int_pending;
            seen.status_code    = req_chan.status_code;
            seen.rx_byte        = req_chan.rx_byte;
            seen.tx_byte        = req_chan.tx_byte;
            pending_actions.push_back(predict_action(seen));
         end
      end
   end

   // Stall the action channel at random
   initial begin : action_sink
      int stall;
      stall = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            stall = idle_len();
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("i2c_master_status_sequencer_unit_test NOT OK");
         $finish;
      end
   end

   function automatic req_type random_fields();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic logic [BYTE_W-1:0] pick_code();
      case ($urandom_range(13))
         0:       return ST_BUS_ERROR;
         1:       return ST_START;
         2:       return ST_RESTART;
         3:       return ST_WADDR_ACK;
         4:       return ST_WADDR_NAK;
         5:       return ST_TX_ACK;
         6:       return ST_TX_NAK;
         7:       return ST_RADDR_ACK;
         8:       return ST_RADDR_NAK;
         9:       return ST_RX_ACK;
         10:      return ST_RX_NAK;
         default: return BYTE_W'($urandom_range(255));
      endcase
   endfunction

   // Present one item, hold it until taken, then maybe idle
   task automatic send_item(input req_type it);
      int gap;
      req_chan.valid          <= 1'b1;
      req_chan.mode           <= it.mode;
      req_chan.slave_addr     <= it.slave_addr;
      req_chan.read_not_write <= it.read_not_write;
      req_chan.ignore_nak     <= it.ignore_nak;
      req_chan.msg_length     <= it.msg_length;
      req_chan.int_pending    <= it.int_pending;
      req_chan.status_code    <= it.status_code;
      req_chan.rx_byte        <= it.rx_byte;
      req_chan.tx_byte        <= it.tx_byte;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      if (it.mode == MODE_START) starts_sent++;
      else if (it.int_pending) events_sent++;
      gap = idle_len();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_start(input logic [ADDR_W-1:0] addr, input logic rnw,
                             input logic ign, input logic [LEN_W-1:0] len);
      req_type it;
      it                = random_fields();
      it.mode           = MODE_START;
      it.slave_addr     = addr;
      it.read_not_write = rnw;
      it.ignore_nak     = ign;
      it.msg_length     = len;
      send_item(it);
   endtask

   task automatic send_event(input logic [BYTE_W-1:0] code, input logic pend = 1'b1);
      req_type it;
      it             = random_fields();
      it.mode        = MODE_EVENT;
      it.int_pending = pend;
      it.status_code = code;
      send_item(it);
   endtask

   // Write messages: clean finish, NAK abort, NAK ignored
   task automatic test_write_messages();
      send_start(7'h7f, 1'b0, 1'b0, 16'd2);
      send_event(ST_START);
      send_event(ST_WADDR_ACK);
      send_event(ST_TX_ACK);
      send_event(ST_TX_ACK);
      send_start(7'h55, 1'b0, 1'b0, 16'hffff);
      send_event(ST_RESTART);
      send_event(ST_WADDR_NAK);
      send_start(7'h2a, 1'b0, 1'b1, 16'd1);
      send_event(ST_START);
      send_event(ST_WADDR_NAK);
      send_event(ST_TX_NAK);
   endtask

   // Read messages: ACK then drop ACK before the last byte, address NAK both ways
   task automatic test_read_messages();
      send_start(7'h00, 1'b1, 1'b0, 16'd3);
      send_event(ST_START);
      send_event(ST_RADDR_ACK);
      send_event(ST_RX_ACK);
      send_event(ST_RX_ACK);
      send_event(ST_RX_NAK);
      send_start(7'h11, 1'b1, 1'b0, 16'd5);
      send_event(ST_RADDR_NAK);
      send_start(7'h66, 1'b1, 1'b1, 16'd4);
      send_event(ST_RADDR_NAK);
      send_event(ST_RX_NAK);
   endtask

   // Bus error, stray status, interrupt flag clear, receive past the end
   task automatic test_status_faults();
      send_event(ST_BUS_ERROR);
      send_event(8'hff);
      send_event(ST_START, 1'b0);
      send_start(7'h3c, 1'b1, 1'b0, 16'd0);
      send_event(ST_RX_ACK);
      send_event(ST_RX_NAK);
   endtask

   // Receive a long burst at full rate, through the ACK drop and past the end
   task automatic test_rx_burst();
      quiet = 1'b1;
      send_start(7'h5a, 1'b1, 1'b1, 16'd30);
      repeat (40) send_event(ST_RX_ACK);
      quiet = 1'b0;
   endtask

   // Mostly well-formed messages with random content, some cut short, plus noise
   task automatic test_random_traffic();
      int          goal;
      logic        rnw;
      logic [LEN_W-1:0] len;
      int          steps;
      int          cut;
      req_type     it;
      goal = starts_sent + events_sent + RANDOM_ITEMS;
      while (starts_sent + events_sent < goal) begin
         quiet = ($urandom_range(7) == 0);
         rnw   = 1'($urandom_range(1));
         len   = ($urandom_range(15) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(6));
         steps = (len > 8) ? 8 : int'(len);
         cut   = ($urandom_range(6) == 0) ? $urandom_range(steps + 1) : steps + 2;
         send_start(7'($urandom_range(127)), rnw, $urandom_range(3) == 0, len);
         send_event($urandom_range(1) ? ST_START : ST_RESTART);
         if (!rnw) begin
            send_event(($urandom_range(9) == 0) ? ST_WADDR_NAK : ST_WADDR_ACK);
            for (int i = 0; i <= steps && i != cut; i++)
               send_event(($urandom_range(9) == 0) ? ST_TX_NAK : ST_TX_ACK);
         end else begin
            send_event(($urandom_range(9) == 0) ? ST_RADDR_NAK : ST_RADDR_ACK);
            for (int i = 0; i < steps && i != cut; i++)
               send_event((i == steps - 1 || $urandom_range(15) == 0) ? ST_RX_NAK : ST_RX_ACK);
         end
         // Stray events between messages
         if ($urandom_range(9) < 3) begin
            repeat ($urandom_range(1, 3)) begin
               it             = random_fields();
               it.mode        = MODE_EVENT;
               it.status_code = pick_code();
               send_item(it);
            end
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.mode           <= MODE_START;
      req_chan.slave_addr     <= '0;
      req_chan.read_not_write <= 1'b0;
      req_chan.ignore_nak     <= 1'b0;
      req_chan.msg_length     <= '0;
      req_chan.int_pending    <= 1'b0;
      req_chan.status_code    <= ST_BUS_ERROR;
      req_chan.rx_byte        <= '0;
      req_chan.tx_byte        <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_write_messages();
      test_read_messages();
      test_status_faults();
      test_rx_burst();
      test_random_traffic();

      // Drain outstanding actions, then allow for the pipeline
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_actions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Ran %0d message starts and %0d handled status events, %0d actions checked.",
               starts_sent, events_sent, actions_checked);
      $display("Covered writes, reads, NAK paths, bus errors, stray codes and long rx bursts.");
      if (mismatches == 0) begin
         $display("i2c_master_status_sequencer_unit_test OK");
      end else begin
         $display("i2c_master_status_sequencer_unit_test NOT OK");
      end
      $finish;
   end

endmodule
